/* rtl/core/esc_pkg.sv */
// ---------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and helpers of the sensor compensation pipeline.
// ---------------------------------------------------------------------------
package esc_pkg;

    // Number of quotient bits, one per divider stage
    localparam int DIV_STEPS = 64;

    localparam logic [31:0] C_T_ROUND   = 32'd128;
    localparam logic [63:0] C_P_OFFSET  = 64'd128000;
    localparam logic [63:0] C_P_BIAS    = 64'd1 << 47;
    localparam logic [63:0] C_P_FULL    = 64'd1048576;
    localparam logic [63:0] C_P_SCALE   = 64'd3125;
    localparam logic [31:0] C_H_OFFSET  = 32'd76800;
    localparam logic [31:0] C_H_ROUND_L = 32'd16384;
    localparam logic [31:0] C_H_BIAS_A  = 32'd32768;
    localparam logic [31:0] C_H_BIAS_B  = 32'd2097152;
    localparam logic [31:0] C_H_ROUND_R = 32'd8192;
    localparam logic [31:0] C_H_MAX     = 32'd419430400;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TEMP   = 3'd0,
        REG_PRESSA = 3'd1,
        REG_PRESSB = 3'd2,
        REG_PRESSC = 3'd3,
        REG_HUMA   = 3'd4,
        REG_HUMB   = 3'd5
    } t_cfg_reg;

    // Packed calibration words as written
    typedef struct packed {
        logic [47:0] temp;
        logic [47:0] pa;
        logic [47:0] pb;
        logic [47:0] pc;
        logic [31:0] ha;
        logic [39:0] hb;
    } t_calib;

    // Side data that travels through the divider with each request
    typedef struct packed {
        logic        neg;
        logic        invalid;
        logic [31:0] temp;
        logic [16:0] hum;
    } t_side;

    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [5:0] n);
        logic signed [31:0] s;
        s = x;
        return s >>> n;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input logic [5:0] n);
        logic signed [63:0] s;
        s = x;
        return s >>> n;
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

endpackage

/* rtl/core/environmental_sensor_compensation_top.sv */
// ---------------------------------------------------------------------------
// environmental_sensor_compensation_top
// Integer compensation of temperature, pressure and humidity readings.
// ---------------------------------------------------------------------------
// Takes one reading set per cycle unless the output stalls, and returns one
// result per reading, in order, after nine stages for temperature, humidity
// and the pressure terms, 64 stages of the pressure divider (one quotient bit
// each) and four stages of pressure correction ending in the result register.
// The whole pipeline advances together whenever the result register is empty
// or being taken, so a stall on the output holds every stage in place.
// Calibration words are written through the configuration channel, which is
// always ready; write them only while no reading is in flight.
module environmental_sensor_compensation_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    // Reading input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // adc_temp[19:0], adc_press[39:20], adc_hum[55:40]
    // Result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,  // temperature[31:0], pressure[63:32],
                                       // humidity[80:64], zero[87:81]
    output logic        m_axis_tuser   // press_invalid
);

    esc_pkg::t_calib r_calib;

    // Store calibration words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                esc_pkg::REG_TEMP:   r_calib.temp <= i_cfg_data;
                esc_pkg::REG_PRESSA: r_calib.pa   <= i_cfg_data;
                esc_pkg::REG_PRESSB: r_calib.pb   <= i_cfg_data;
                esc_pkg::REG_PRESSC: r_calib.pc   <= i_cfg_data;
                esc_pkg::REG_HUMA:   r_calib.ha   <= i_cfg_data[31:0];
                esc_pkg::REG_HUMB:   r_calib.hb   <= i_cfg_data[39:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Advance the pipeline when the result register can take a request
    logic w_en;
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    logic           w_f_v;
    esc_pkg::t_side w_f_side;
    logic [63:0]    w_f_dvd;
    logic [31:0]    w_f_dvs;

    esc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (s_axis_tvalid),
        .i_adc_temp  (s_axis_tdata[19:0]),
        .i_adc_press (s_axis_tdata[39:20]),
        .i_adc_hum   (s_axis_tdata[55:40]),
        .i_calib     (r_calib),
        .o_valid     (w_f_v),
        .o_side      (w_f_side),
        .o_dvd_mag   (w_f_dvd),
        .o_dvs_mag   (w_f_dvs)
    );

    logic           w_d_v;
    esc_pkg::t_side w_d_side;
    logic [63:0]    w_d_quot;

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_v),
        .i_side  (w_f_side),
        .i_dvd   (w_f_dvd),
        .i_dvs   (w_f_dvs),
        .o_valid (w_d_v),
        .o_side  (w_d_side),
        .o_quot  (w_d_quot)
    );

    logic [31:0] w_temp, w_press;
    logic [16:0] w_hum;

    esc_press u_press (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_valid         (w_d_v),
        .i_side          (w_d_side),
        .i_quot          (w_d_quot),
        .i_calib         (r_calib),
        .o_valid         (m_axis_tvalid),
        .o_temperature   (w_temp),
        .o_pressure      (w_press),
        .o_humidity      (w_hum),
        .o_press_invalid (m_axis_tuser)
    );

    assign m_axis_tdata = {7'd0, w_hum, w_press, w_temp};

    // Forced pressure is zero whenever the divisor was zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:32] == 32'd0)
        else $error("pressure not cleared on zero divisor");

    // Humidity never exceeds full scale
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[80:64] <= 17'd102400)
        else $error("humidity above full scale");

    // No result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid after reset");

    // No input taken while the result output is stalled
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted during output stall");

endmodule

/* rtl/core/esc_front.sv */
// ---------------------------------------------------------------------------
// esc_front
// Temperature and humidity paths, and the pressure terms up to the divider.
// ---------------------------------------------------------------------------
module esc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [19:0]          i_adc_temp,
    input  logic [19:0]          i_adc_press,
    input  logic [15:0]          i_adc_hum,
    input  esc_pkg::t_calib      i_calib,
    output logic                 o_valid,
    output esc_pkg::t_side       o_side,
    output logic [63:0]          o_dvd_mag,
    output logic [31:0]          o_dvs_mag
);

    // Calibration fields
    logic [31:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    assign t1 = {16'd0, i_calib.temp[15:0]};
    assign t2 = {{16{i_calib.temp[31]}}, i_calib.temp[31:16]};
    assign t3 = {{16{i_calib.temp[47]}}, i_calib.temp[47:32]};
    assign p1 = {48'd0, i_calib.pa[15:0]};
    assign p2 = esc_pkg::sx16(i_calib.pa[31:16]);
    assign p3 = esc_pkg::sx16(i_calib.pa[47:32]);
    assign p4 = esc_pkg::sx16(i_calib.pb[15:0]);
    assign p5 = esc_pkg::sx16(i_calib.pb[31:16]);
    assign p6 = esc_pkg::sx16(i_calib.pb[47:32]);
    assign h1 = {24'd0, i_calib.ha[7:0]};
    assign h2 = {{16{i_calib.ha[23]}}, i_calib.ha[23:8]};
    assign h3 = {24'd0, i_calib.ha[31:24]};
    assign h4 = {{16{i_calib.hb[15]}}, i_calib.hb[15:0]};
    assign h5 = {{16{i_calib.hb[31]}}, i_calib.hb[31:16]};
    assign h6 = {{24{i_calib.hb[39]}}, i_calib.hb[39:32]};

    // Stage A: first temperature products
    logic        r_a_v;
    logic [31:0] r_a_ta, r_a_dd;
    logic [19:0] r_a_rp;
    logic [15:0] r_a_rh;
    logic [31:0] n_a_e, n_a_d;

    assign n_a_e = {15'd0, i_adc_temp[19:3]} - {t1[30:0], 1'b0};
    assign n_a_d = {16'd0, i_adc_temp[19:4]} - t1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ta <= n_a_e * t2;
            r_a_dd <= n_a_d * n_a_d;
            r_a_rp <= i_adc_press;
            r_a_rh <= i_adc_hum;
        end
    end

    // Stage B: scale the square term by T3
    logic        r_b_v;
    logic [31:0] r_b_a, r_b_b;
    logic [19:0] r_b_rp;
    logic [15:0] r_b_rh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_a  <= esc_pkg::asr32(r_a_ta, 6'd11);
            r_b_b  <= esc_pkg::asr32(r_a_dd, 6'd12) * t3;
            r_b_rp <= r_a_rp;
            r_b_rh <= r_a_rh;
        end
    end

    // Stage C: fine temperature
    logic        r_c_v;
    logic [31:0] r_c_fine;
    logic [19:0] r_c_rp;
    logic [15:0] r_c_rh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_fine <= r_b_a + esc_pkg::asr32(r_b_b, 6'd14);
            r_c_rp   <= r_b_rp;
            r_c_rh   <= r_b_rh;
        end
    end

    // Stage D: temperature result and first products of fine temperature
    logic               r_d_v;
    logic [31:0]        r_d_temp, r_d_h5x, r_d_xh6, r_d_xh3;
    logic [63:0]        r_d_v1sq, r_d_v1p5, r_d_v1p2;
    logic [19:0]        r_d_rp;
    logic [15:0]        r_d_rh;
    logic signed [32:0] n_d_v1;
    logic signed [65:0] n_d_sq;
    logic signed [63:0] n_d_v1p5, n_d_v1p2;
    logic [31:0]        n_d_x;

    always_comb begin
        n_d_v1   = $signed({r_c_fine[31], r_c_fine}) - $signed(33'd128000);
        n_d_sq   = n_d_v1 * n_d_v1;
        n_d_v1p5 = n_d_v1 * $signed(p5[15:0]);
        n_d_v1p2 = n_d_v1 * $signed(p2[15:0]);
        n_d_x    = r_c_fine - esc_pkg::C_H_OFFSET;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (i_en) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_temp <= esc_pkg::asr32({r_c_fine[29:0], 2'b00} + r_c_fine
                                       + esc_pkg::C_T_ROUND, 6'd8);
            r_d_v1sq <= n_d_sq[63:0];
            r_d_v1p5 <= n_d_v1p5;
            r_d_v1p2 <= n_d_v1p2;
            r_d_h5x  <= h5 * n_d_x;
            r_d_xh6  <= n_d_x * h6;
            r_d_xh3  <= n_d_x * h3;
            r_d_rp   <= r_c_rp;
            r_d_rh   <= r_c_rh;
        end
    end

    // Stage E: second-order pressure terms, humidity left factor
    logic        r_e_v;
    logic [31:0] r_e_temp, r_e_hl, r_e_r1;
    logic [63:0] r_e_v2a, r_e_v1a, r_e_v1p5, r_e_v1p2;
    logic [19:0] r_e_rp;
    logic [31:0] n_e_hsum;

    assign n_e_hsum = {2'd0, r_d_rh, 14'd0} - {h4[11:0], 20'd0} - r_d_h5x
                      + esc_pkg::C_H_ROUND_L;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (i_en) begin
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_temp <= r_d_temp;
            r_e_v2a  <= r_d_v1sq * p6;
            r_e_v1a  <= r_d_v1sq * p3;
            r_e_v1p5 <= r_d_v1p5;
            r_e_v1p2 <= r_d_v1p2;
            r_e_hl   <= esc_pkg::asr32(n_e_hsum, 6'd15);
            r_e_r1   <= esc_pkg::asr32(r_d_xh6, 6'd10)
                        * (esc_pkg::asr32(r_d_xh3, 6'd11) + esc_pkg::C_H_BIAS_A);
            r_e_rp   <= r_d_rp;
        end
    end

    // Stage F: sum the pressure terms, humidity H2 product
    logic        r_f_v;
    logic [31:0] r_f_temp, r_f_hl, r_f_r2;
    logic [63:0] r_f_v2, r_f_v1b;
    logic [19:0] r_f_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (i_en) begin
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_temp <= r_e_temp;
            r_f_v2   <= r_e_v2a + {r_e_v1p5[46:0], 17'd0} + {p4[28:0], 35'd0};
            r_f_v1b  <= esc_pkg::asr64(r_e_v1a, 6'd8) + {r_e_v1p2[51:0], 12'd0};
            r_f_hl   <= r_e_hl;
            r_f_r2   <= (esc_pkg::asr32(r_e_r1, 6'd10) + esc_pkg::C_H_BIAS_B) * h2;
            r_f_rp   <= r_e_rp;
        end
    end

    // Stage G: divisor product, scaled dividend, humidity product
    logic        r_g_v;
    logic [31:0] r_g_temp, r_g_hx;
    logic [63:0] r_g_dvp, r_g_num;
    logic [63:0] n_g_pn;

    assign n_g_pn = esc_pkg::C_P_FULL - {44'd0, r_f_rp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (i_en) begin
            r_g_v <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g_temp <= r_f_temp;
            r_g_dvp  <= (esc_pkg::C_P_BIAS + r_f_v1b) * p1;
            r_g_num  <= ({n_g_pn[32:0], 31'd0} - r_f_v2) * esc_pkg::C_P_SCALE;
            r_g_hx   <= r_f_hl * esc_pkg::asr32(r_f_r2 + esc_pkg::C_H_ROUND_R, 6'd14);
        end
    end

    // Stage H: divisor, humidity square term
    logic        r_h_v;
    logic [31:0] r_h_temp, r_h_hx, r_h_ss;
    logic [63:0] r_h_dvs, r_h_num;
    logic [31:0] n_h_s;

    assign n_h_s = esc_pkg::asr32(r_g_hx, 6'd15);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else if (i_en) begin
            r_h_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h_temp <= r_g_temp;
            r_h_dvs  <= esc_pkg::asr64(r_g_dvp, 6'd33);
            r_h_num  <= r_g_num;
            r_h_hx   <= r_g_hx;
            r_h_ss   <= n_h_s * n_h_s;
        end
    end

    // Stage I: humidity clamp, magnitudes and sign for the divider
    logic           r_i_v;
    esc_pkg::t_side r_i_side;
    logic [63:0]    r_i_dvd;
    logic [31:0]    r_i_dvs;
    logic [31:0]    n_i_hx, n_i_hc;
    logic [63:0]    n_i_dvs;

    always_comb begin
        n_i_hx = r_h_hx - esc_pkg::asr32(esc_pkg::asr32(r_h_ss, 6'd7) * h1, 6'd4);
        priority if (n_i_hx[31]) begin
            n_i_hc = 32'd0;
        end else if (n_i_hx > esc_pkg::C_H_MAX) begin
            n_i_hc = esc_pkg::C_H_MAX;
        end else begin
            n_i_hc = n_i_hx;
        end
        n_i_dvs = r_h_dvs[63] ? (64'd0 - r_h_dvs) : r_h_dvs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v <= 1'b0;
        end else if (i_en) begin
            r_i_v <= r_h_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_i_side.neg     <= r_h_num[63] ^ r_h_dvs[63];
            r_i_side.invalid <= (r_h_dvs == 64'd0);
            r_i_side.temp    <= r_h_temp;
            r_i_side.hum     <= n_i_hc[28:12];
            r_i_dvd          <= r_h_num[63] ? (64'd0 - r_h_num) : r_h_num;
            r_i_dvs          <= n_i_dvs[31:0];
        end
    end

    assign o_valid   = r_i_v;
    assign o_side    = r_i_side;
    assign o_dvd_mag = r_i_dvd;
    assign o_dvs_mag = r_i_dvs;

endmodule

/* rtl/core/esc_div.sv */
// ---------------------------------------------------------------------------
// esc_div
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// ---------------------------------------------------------------------------
module esc_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  esc_pkg::t_side  i_side,
    input  logic [63:0]     i_dvd,
    input  logic [31:0]     i_dvs,
    output logic            o_valid,
    output esc_pkg::t_side  o_side,
    output logic [63:0]     o_quot
);

    localparam int N = esc_pkg::DIV_STEPS;

    // Per stage: remainder, dividend bits shifting out / quotient shifting in
    logic           r_v    [N+1];
    logic [31:0]    r_rem  [N+1];
    logic [63:0]    r_q    [N+1];
    logic [31:0]    r_dvs  [N+1];
    esc_pkg::t_side r_side [N+1];

    // Stage zero is the request itself
    always_comb begin
        r_v[0]    = i_valid;
        r_rem[0]  = 32'd0;
        r_q[0]    = i_dvd;
        r_dvs[0]  = i_dvs;
        r_side[0] = i_side;
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [32:0] n_sh;
        logic        n_ge;
        logic [32:0] n_diff;

        assign n_sh   = {r_rem[k], r_q[k][63]};
        assign n_ge   = (n_sh >= {1'b0, r_dvs[k]});
        assign n_diff = n_sh - {1'b0, r_dvs[k]};

        // Advance valid with the data
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        // Subtract when the shifted remainder covers the divisor
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_ge ? n_diff[31:0] : n_sh[31:0];
                r_q[k+1]    <= {r_q[k][62:0], n_ge};
                r_dvs[k+1]  <= r_dvs[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_side  = r_side[N];
    assign o_quot  = r_q[N];

endmodule

/* rtl/core/esc_press.sv */
// ---------------------------------------------------------------------------
// esc_press
// Pressure correction after the division and the result register.
// ---------------------------------------------------------------------------
module esc_press (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  esc_pkg::t_side  i_side,
    input  logic [63:0]     i_quot,
    input  esc_pkg::t_calib i_calib,
    output logic            o_valid,
    output logic [31:0]     o_temperature,
    output logic [31:0]     o_pressure,
    output logic [16:0]     o_humidity,
    output logic            o_press_invalid
);

    logic [63:0] p7, p8, p9;

    assign p7 = esc_pkg::sx16(i_calib.pc[15:0]);
    assign p8 = esc_pkg::sx16(i_calib.pc[31:16]);
    assign p9 = esc_pkg::sx16(i_calib.pc[47:32]);

    // Stage J: signed quotient, partial squares, P8 product
    logic           r_j_v;
    esc_pkg::t_side r_j_side;
    logic [63:0]    r_j_p, r_j_ll, r_j_p8p;
    logic [31:0]    r_j_lh;
    logic [63:0]    n_j_p, n_j_ps;

    always_comb begin
        n_j_p  = i_side.neg ? (64'd0 - i_quot) : i_quot;
        n_j_ps = esc_pkg::asr64(n_j_p, 6'd13);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_v <= 1'b0;
        end else if (i_en) begin
            r_j_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_j_side <= i_side;
            r_j_p    <= n_j_p;
            r_j_ll   <= {32'd0, n_j_ps[31:0]} * {32'd0, n_j_ps[31:0]};
            r_j_lh   <= n_j_ps[31:0] * n_j_ps[63:32];
            r_j_p8p  <= n_j_p * p8;
        end
    end

    // Stage K: assemble the square
    logic           r_k_v;
    esc_pkg::t_side r_k_side;
    logic [63:0]    r_k_p, r_k_pss, r_k_p8p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_v <= 1'b0;
        end else if (i_en) begin
            r_k_v <= r_j_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k_side <= r_j_side;
            r_k_p    <= r_j_p;
            r_k_pss  <= r_j_ll + {r_j_lh[30:0], 33'd0};
            r_k_p8p  <= r_j_p8p;
        end
    end

    // Stage L: P9 term and scaled P8 term
    logic           r_l_v;
    esc_pkg::t_side r_l_side;
    logic [63:0]    r_l_p, r_l_v1, r_l_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_v <= 1'b0;
        end else if (i_en) begin
            r_l_v <= r_k_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l_side <= r_k_side;
            r_l_p    <= r_k_p;
            r_l_v1   <= esc_pkg::asr64(r_k_pss * p9, 6'd25);
            r_l_v2   <= esc_pkg::asr64(r_k_p8p, 6'd19);
        end
    end

    // Stage M: final sum into the result register
    logic        r_m_v;
    logic [31:0] r_m_temp, r_m_press;
    logic [16:0] r_m_hum;
    logic        r_m_inv;
    logic [63:0] n_m_p;

    assign n_m_p = esc_pkg::asr64(r_l_p + r_l_v1 + r_l_v2, 6'd8) + {p7[59:0], 4'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (i_en) begin
            r_m_v <= r_l_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_temp  <= r_l_side.temp;
            r_m_hum   <= r_l_side.hum;
            r_m_inv   <= r_l_side.invalid;
            r_m_press <= r_l_side.invalid ? 32'd0 : n_m_p[31:0];
        end
    end

    assign o_valid         = r_m_v;
    assign o_temperature   = r_m_temp;
    assign o_pressure      = r_m_press;
    assign o_humidity      = r_m_hum;
    assign o_press_invalid = r_m_inv;

endmodule
